[sv/lpr_pkg.sv]
// Package for the LRU page replacement block: sizes, field widths and the
// register map of the configuration port. No dependencies.
package lpr_pkg;

  localparam int FRAMES      = 4;
  localparam int PAGE_SIZE   = 16;
  localparam int ADDR_W      = 16;
  localparam int AGE_W       = 16;

  localparam int OFFSET_W    = $clog2(PAGE_SIZE);
  localparam int PAGE_W      = ADDR_W - OFFSET_W;
  localparam int FRAME_IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FILL_W      = $clog2(FRAMES + 1);
  localparam int LIMIT_W     = 3;
  localparam int MISS_W      = 16;

  localparam logic [AGE_W-1:0]   AGE_MAX     = {AGE_W{1'b1}};
  localparam logic [MISS_W-1:0]  MISS_MAX    = {MISS_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

  // Register map: word index taken from paddr above the byte lanes.
  localparam int PADDR_W = 3;
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [AGE_W-1:0]  age_t;

endpackage

[sv/lru_page_replacement.sv]
// Top level of the LRU page replacement block (aging counters).
// Depends on lpr_pkg for sizes, widths and the register map.
//
// Usage
//   A request is an access address on in_access_address, taken at a rising
//   edge where start is high and busy is low. busy is held low: a request
//   may be issued in every cycle.
//   The address is split into a page number and an in-page offset. The
//   resident frames are searched for the page; a hit clears that frame's
//   age, a miss fills the next free frame while the frames_in_use limit
//   allows, and otherwise replaces the oldest frame (lowest index on a tie).
//   Every occupied frame then ages by one, saturating.
//   Pipeline: the request is captured in an input register, the lookup and
//   update are done in the following cycle and the answer is captured in
//   the result register, so out_valid is high for one cycle. Throughput is
//   one request per cycle, set by the single lookup-and-update stage, which
//   reads the state left by the previous request.
//   The receiver cannot stall: each result is shown for exactly one cycle.
//   Reset (rst_n low, synchronous) empties all frames, clears the ages and
//   the miss total, drops any request in flight and sets frames_in_use to 3.
//   frames_in_use sits at byte address 0 of the APB port; pready is always
//   high and it should only be written while no request is in flight.
module lru_page_replacement
  import lpr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   start,
  output logic                   busy,
  input  logic [ADDR_W-1:0]      in_access_address,
  // result channel
  output logic                   out_valid,
  output logic                   out_hit,
  output logic [FRAME_IDX_W-1:0] out_frame_index,
  output logic [PAGE_W-1:0]      out_page_number,
  output logic [OFFSET_W-1:0]    out_page_offset,
  output logic                   out_evicted,
  output logic [PAGE_W-1:0]      out_evicted_page,
  output logic [MISS_W-1:0]      out_miss_total,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Configuration register.
  logic [LIMIT_W-1:0] frames_in_use_r;
  logic               cfg_wr;

  // Input register.
  logic              in_vld_r;
  logic [ADDR_W-1:0] in_addr_r;

  // Replacement state. Page tags are only read for occupied frames, so
  // they carry no reset.
  page_t             frame_page_r [FRAMES];
  age_t              frame_age_r  [FRAMES];
  logic [FILL_W-1:0] filled_r;
  logic [MISS_W-1:0] miss_r;

  // Result register.
  logic                   out_valid_r;
  logic                   res_hit_r;
  logic [FRAME_IDX_W-1:0] res_slot_r;
  page_t                  res_page_r;
  logic [OFFSET_W-1:0]    res_offset_r;
  logic                   res_evict_r;
  page_t                  res_old_page_r;
  logic [MISS_W-1:0]      res_miss_r;

  // Next values.
  page_t                  page;
  logic [OFFSET_W-1:0]    offset;
  logic [LIMIT_W-1:0]     limit;
  logic                   hit;
  logic [FRAME_IDX_W-1:0] hit_slot;
  logic [FRAME_IDX_W-1:0] old_slot;
  logic [FRAME_IDX_W-1:0] slot;
  logic                   fill;
  logic                   evict;
  logic [FILL_W-1:0]      filled_nxt;
  logic [MISS_W-1:0]      miss_nxt;
  age_t                   frame_age_nxt [FRAMES];
  page_t                  old_page;

  // ---------------------------------------------------------------------
  // APB port. Word index sits above the two byte-lane bits.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[PADDR_W-1] == REG_FRAMES_IN_USE);

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_FRAMES_IN_USE) begin
      prdata = 32'(frames_in_use_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      frames_in_use_r <= pwdata[LIMIT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Input register. A request is taken in every cycle that start is high.
  // ---------------------------------------------------------------------
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_addr_r <= in_access_address;
    end
  end

  // ---------------------------------------------------------------------
  // Lookup and update.
  // ---------------------------------------------------------------------
  assign page   = in_addr_r[ADDR_W-1:OFFSET_W];
  assign offset = in_addr_r[OFFSET_W-1:0];

  // A limit of zero behaves as one, anything above the frame count as the
  // frame count.
  always_comb begin
    if (frames_in_use_r == '0) begin
      limit = LIMIT_W'(1);
    end else if (32'(frames_in_use_r) > FRAMES) begin
      limit = LIMIT_W'(FRAMES);
    end else begin
      limit = frames_in_use_r;
    end
  end

  // Hit search over occupied frames; the lowest index wins.
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if ((FILL_W'(i) < filled_r) && (frame_page_r[i] == page)) begin
        hit      = 1'b1;
        hit_slot = FRAME_IDX_W'(i);
      end
    end
  end

  // Oldest occupied frame; a strict compare keeps the lowest index on ties.
  always_comb begin
    old_slot = '0;
    for (int i = 1; i < FRAMES; i++) begin
      if ((FILL_W'(i) < filled_r) && (frame_age_r[i] > frame_age_r[old_slot])) begin
        old_slot = FRAME_IDX_W'(i);
      end
    end
  end

  always_comb begin
    fill       = !hit && (32'(filled_r) < 32'(limit));
    evict      = !hit && !fill;
    filled_nxt = fill ? filled_r + FILL_W'(1) : filled_r;
    miss_nxt   = (!hit && miss_r != MISS_MAX) ? miss_r + MISS_W'(1) : miss_r;
    old_page   = frame_page_r[old_slot];
    if (hit) begin
      slot = hit_slot;
    end else if (fill) begin
      slot = filled_r[FRAME_IDX_W-1:0];
    end else begin
      slot = old_slot;
    end
  end

  // The touched frame restarts at zero, then every occupied frame ages.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      frame_age_nxt[i] = (FRAME_IDX_W'(i) == slot) ? '0 : frame_age_r[i];
      if ((FILL_W'(i) < filled_nxt) && (frame_age_nxt[i] != AGE_MAX)) begin
        frame_age_nxt[i] = frame_age_nxt[i] + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      miss_r   <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        frame_age_r[i] <= '0;
      end
    end else if (in_vld_r) begin
      filled_r <= filled_nxt;
      miss_r   <= miss_nxt;
      for (int i = 0; i < FRAMES; i++) begin
        frame_age_r[i] <= frame_age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r && !hit) begin
      frame_page_r[slot] <= page;
    end
  end

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      res_hit_r      <= hit;
      res_slot_r     <= slot;
      res_page_r     <= page;
      res_offset_r   <= offset;
      res_evict_r    <= evict;
      res_old_page_r <= evict ? old_page : '0;
      res_miss_r     <= miss_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = res_hit_r;
  assign out_frame_index  = res_slot_r;
  assign out_page_number  = res_page_r;
  assign out_page_offset  = res_offset_r;
  assign out_evicted      = res_evict_r;
  assign out_evicted_page = res_old_page_r;
  assign out_miss_total   = res_miss_r;

endmodule

[verif/lpr_checker.sv]
// Checker for the LRU page replacement block: watches the request, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on lpr_pkg for widths, saturation limits and the register map.
module lpr_checker
  import lpr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [ADDR_W-1:0]      in_access_address,
  input  logic                   out_valid,
  input  logic                   out_hit,
  input  logic [FRAME_IDX_W-1:0] out_frame_index,
  input  logic [PAGE_W-1:0]      out_page_number,
  input  logic [OFFSET_W-1:0]    out_page_offset,
  input  logic                   out_evicted,
  input  logic [PAGE_W-1:0]      out_evicted_page,
  input  logic [MISS_W-1:0]      out_miss_total,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  input  logic [31:0]            prdata,
  input  logic                   pready,
  output int                     fail_count,
  output int                     pending_count,
  output int                     hit_count,
  output int                     evict_count
);

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame;
    page_t                  page;
    logic [OFFSET_W-1:0]    offset;
    logic                   evicted;
    page_t                  evicted_page;
    logic [MISS_W-1:0]      miss_total;
  } access_result_t;

  access_result_t      expected_q[$];
  page_t               resident_page[FRAMES];
  age_t                frame_age[FRAMES];
  int                  occupied;
  logic [MISS_W-1:0]   miss_tally;
  logic [LIMIT_W-1:0]  limit_reg;
  int                  errors = 0;
  int                  results_seen = 0;
  int                  hits = 0;
  int                  evictions = 0;

  assign fail_count  = errors;
  assign hit_count   = hits;
  assign evict_count = evictions;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("checker: %s differs at result %0d: got %0h, expected %0h",
             what, results_seen, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Works out the answer to one access and updates the frame table.
  task automatic predict_access(input logic [ADDR_W-1:0] addr);
    access_result_t r;
    page_t          pg;
    int             lim;
    int             slot;
    bit             found;
    pg    = addr[ADDR_W-1:OFFSET_W];
    lim   = (limit_reg == 0) ? 1 : ((limit_reg > FRAMES) ? FRAMES : int'(limit_reg));
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < occupied; i++) begin
      if (!found && resident_page[i] == pg) begin
        found = 1'b1;
        slot  = i;
      end
    end
    r        = '0;
    r.hit    = found;
    r.page   = pg;
    r.offset = addr[OFFSET_W-1:0];
    if (!found) begin
      if (miss_tally != MISS_MAX) miss_tally++;
      if (occupied < lim) begin
        slot = occupied;
        occupied++;
      end else begin
        // Oldest frame goes; the strict compare keeps the lowest index on a tie.
        slot = 0;
        for (int i = 1; i < occupied; i++) begin
          if (frame_age[i] > frame_age[slot]) slot = i;
        end
        r.evicted      = 1'b1;
        r.evicted_page = resident_page[slot];
      end
      resident_page[slot] = pg;
    end
    frame_age[slot] = '0;
    for (int i = 0; i < occupied; i++) begin
      if (frame_age[i] != AGE_MAX) frame_age[i]++;
    end
    r.frame      = slot[FRAME_IDX_W-1:0];
    r.miss_total = miss_tally;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      expected_q.delete();
      for (int i = 0; i < FRAMES; i++) frame_age[i] = '0;
      occupied      = 0;
      miss_tally    = '0;
      limit_reg     = LIMIT_RESET;
      pending_count <= 0;
    end else begin
      // A result leaves before a new request enters, so the oldest is popped first.
      if (out_valid === 1'b1) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_page_number), 32'd0);
        end else begin
          want = expected_q.pop_front();
          check_field("hit", 32'(out_hit), 32'(want.hit));
          check_field("frame_index", 32'(out_frame_index), 32'(want.frame));
          check_field("page_number", 32'(out_page_number), 32'(want.page));
          check_field("page_offset", 32'(out_page_offset), 32'(want.offset));
          check_field("evicted", 32'(out_evicted), 32'(want.evicted));
          check_field("evicted_page", 32'(out_evicted_page), 32'(want.evicted_page));
          check_field("miss_total", 32'(out_miss_total), 32'(want.miss_total));
          if (want.hit) hits++;
          if (want.evicted) evictions++;
        end
        results_seen++;
      end
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_FRAMES_IN_USE) begin
        if (pwrite)
          limit_reg = pwdata[LIMIT_W-1:0];
        else
          check_field("frames_in_use readback", prdata, 32'(limit_reg));
      end
      if (start === 1'b1 && busy === 1'b0) predict_access(in_access_address);
      pending_count <= expected_q.size();
    end
  end

endmodule

[verif/tb_top.sv]
// Testbench top for the LRU page replacement block: clock, reset, request and
// register stimulus, and the verdict. Depends on lpr_pkg, lru_page_replacement
// and lpr_checker, which predicts and compares every result.
module tb_top;
  import lpr_pkg::*;

  // The run is short in practice; this limit only catches a block that
  // has stopped answering.
  localparam int CYCLE_LIMIT      = 100_000;
  localparam int RANDOM_PER_PHASE = 500;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [ADDR_W-1:0]      in_access_address;
  logic                   out_valid;
  logic                   out_hit;
  logic [FRAME_IDX_W-1:0] out_frame_index;
  logic [PAGE_W-1:0]      out_page_number;
  logic [OFFSET_W-1:0]    out_page_offset;
  logic                   out_evicted;
  logic [PAGE_W-1:0]      out_evicted_page;
  logic [MISS_W-1:0]      out_miss_total;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  int fail_count;
  int pending_count;
  int hit_count;
  int evict_count;
  int cycle_count = 0;
  int requests_sent = 0;
  int settings_written = 0;

  always #6 clk = ~clk;

  lru_page_replacement DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_access_address (in_access_address),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_page_number   (out_page_number),
    .out_page_offset   (out_page_offset),
    .out_evicted       (out_evicted),
    .out_evicted_page  (out_evicted_page),
    .out_miss_total    (out_miss_total),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  lpr_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_access_address (in_access_address),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_page_number   (out_page_number),
    .out_page_offset   (out_page_offset),
    .out_evicted       (out_evicted),
    .out_evicted_page  (out_evicted_page),
    .out_miss_total    (out_miss_total),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .fail_count        (fail_count),
    .pending_count     (pending_count),
    .hit_count         (hit_count),
    .evict_count       (evict_count)
  );

  // Watchdog: a hung block must still end the run with a verdict.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Watchdog: no progress after %0d cycles, %0d requests still waiting",
               cycle_count, pending_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Presents one request and holds it until the block takes it. start is left
  // high so that a back-to-back request needs no second assignment in the step.
  task automatic send_access(input logic [ADDR_W-1:0] addr);
    start             <= 1'b1;
    in_access_address <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    requests_sent++;
  endtask

  // A pause with no request; the address lines carry noise meanwhile.
  task automatic idle_cycle();
    start             <= 1'b0;
    in_access_address <= ADDR_W'($urandom);
    @(posedge clk);
  endtask

  // Waits until every request in flight has produced its result. The first
  // edge is always taken so that a request accepted at this very edge is seen
  // in the checker's count before it is read.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Writes frames_in_use and reads it straight back. psel stays high from the
  // write's access phase into the read's setup phase, so that no signal takes
  // two assignments at one edge. Only called with the block idle.
  task automatic write_limit(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FRAMES_IN_USE, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= 32'($urandom);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_written++;
  endtask

  // Random requests in blocks of a hundred. Each block starts idle with a new
  // frames_in_use setting and a small pool of pages, so that most requests hit
  // or fight over the few frames; the rest are arbitrary addresses. Before each
  // request the sender pauses, and pauses again, with the given chance in a hundred.
  task automatic random_phase(input int count, input int idle_pct);
    page_t            pool[6];
    int               pool_n;
    logic [ADDR_W-1:0] addr;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        drain();
        write_limit($urandom_range(0, 7));
        pool_n = $urandom_range(2, 6);
        for (int k = 0; k < 6; k++) begin
          case ($urandom_range(0, 9))
            0: begin
              pool[k] = '0;
            end
            1: begin
              pool[k] = '1;
            end
            default: begin
              pool[k] = PAGE_W'($urandom);
            end
          endcase
        end
      end
      while ($urandom_range(0, 99) < idle_pct) idle_cycle();
      if ($urandom_range(0, 9) < 8)
        addr = {pool[$urandom_range(0, pool_n - 1)], OFFSET_W'($urandom)};
      else
        addr = ADDR_W'($urandom);
      send_access(addr);
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_access_address <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the reset limit of three frames: the lowest
    // and highest addresses, a hit, filling up to the limit and then replacing.
    send_access(16'h0000);
    send_access(16'hFFFF);
    send_access(16'h0005);
    send_access(16'h1230);
    send_access(16'h4567);
    send_access(16'hFFF3);
    drain();
    // Raising the limit to all four frames lets the next miss fill a new frame.
    write_limit(4);
    send_access(16'hABC9);
    send_access(16'h789A);
    send_access(16'h0000);
    drain();
    // Lowering the limit below the occupancy: all four frames stay in play.
    write_limit(1);
    send_access(16'h1111);
    send_access(16'h2222);
    send_access(16'h1115);
    drain();
    // A limit of zero behaves as one.
    write_limit(0);
    send_access(16'h3333);
    send_access(16'h3330);
    send_access(16'h8000);
    drain();
    // A limit above the number of frames behaves as the number of frames.
    write_limit(7);
    send_access(16'h9999);
    send_access(16'hAAAA);
    send_access(16'h5555);
    send_access(16'hFFFF);

    // Random part: the sender first pauses now and then, then mostly, then never.
    random_phase(RANDOM_PER_PHASE, 24);
    random_phase(RANDOM_PER_PHASE, 77);
    random_phase(RANDOM_PER_PHASE, 0);

    drain();
    repeat (4) @(posedge clk);
    $display("Covered %0d requests (%0d hits, %0d replacements) over %0d limit settings,",
             requests_sent, hit_count, evict_count, settings_written);
    $display("including limits out of range or below occupancy, and back-to-back bursts.");
    if (fail_count == 0 && pending_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
